// ===== rtl/dtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types, status codes, character codes and the power-of-ten table
// for the decimal text to fixed-point parser.
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned LEN_W          = 16;
    localparam int unsigned INT_W          = 32;
    localparam int unsigned FRAC_ACC_W     = 30;
    localparam int unsigned FRAC_CNT_W     = 4;
    localparam int unsigned VALUE_W        = 49;
    localparam int unsigned MAG_W          = 48;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned OUT_TDATA_W    = 56;
    localparam int unsigned MAX_FRAC_DIGITS = 9;

    localparam logic [0:0] REG_MAX_LEN = 1'b0;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NODIGIT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LONG    = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

    typedef struct packed {
        logic                clear;
        logic                cnt_inc;
        logic                int_dig;
        logic                frac_dig;
        logic                sign_load;
        logic                div_start;
        logic                div_step;
        logic                load_err;
        logic                load_val;
        logic [STATUS_W-1:0] err_code;
    } t_cmd;

    typedef struct packed {
        logic is_nul;
        logic is_digit;
        logic is_minus;
        logic is_plus;
        logic is_point;
        logic len_hit;
        logic int_seen;
        logic frac_full;
        logic div_last;
    } t_sts;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/dtf_cfg.sv =====
// ----------------------------------------------------------------------------
// dtf_cfg
// APB register file holding the max_length limit.
// ----------------------------------------------------------------------------
module dtf_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [dtf_pkg::LEN_W-1:0] o_max_len
);

    logic [dtf_pkg::LEN_W-1:0] r_max_len;
    logic [dtf_pkg::LEN_W-1:0] n_max_len;
    logic                      w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == dtf_pkg::REG_MAX_LEN);

    always_comb begin
        n_max_len = r_max_len;
        if (w_wr) begin
            n_max_len = pwdata[dtf_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'd32;
        end else begin
            r_max_len <= n_max_len;
        end
    end

    assign prdata    = (paddr[2] == dtf_pkg::REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;
    assign o_max_len = r_max_len;

endmodule

// ===== rtl/dtf_dp.sv =====
// ----------------------------------------------------------------------------
// dtf_dp
// Datapath: character decode, integer and fraction accumulators, length
// counter, bit-serial restoring divider and the result register.
// ----------------------------------------------------------------------------
module dtf_dp #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [dtf_pkg::CHAR_W-1:0]      i_char,
    input  logic [dtf_pkg::LEN_W-1:0]       i_max_len,
    input  dtf_pkg::t_cmd                   i_cmd,
    output dtf_pkg::t_sts                   o_sts,
    output logic [dtf_pkg::VALUE_W-1:0]     o_value,
    output logic [dtf_pkg::STATUS_W-1:0]    o_status
);

    localparam int unsigned STEP_W = $clog2(FRAC_BITS);
    localparam int unsigned IP_W   = dtf_pkg::MAG_W - FRAC_BITS;
    localparam int unsigned REM_W  = dtf_pkg::FRAC_ACC_W + 1;

    logic                                r_neg;
    logic [dtf_pkg::INT_W-1:0]           r_int;
    logic                                r_int_seen;
    logic [dtf_pkg::FRAC_ACC_W-1:0]      r_frac;
    logic [dtf_pkg::FRAC_CNT_W-1:0]      r_frac_cnt;
    logic [dtf_pkg::LEN_W-1:0]           r_cnt;
    logic [REM_W-1:0]                    r_rem;
    logic [dtf_pkg::FRAC_ACC_W-1:0]      r_div;
    logic [FRAC_BITS-1:0]                r_quo;
    logic [STEP_W-1:0]                   r_step;
    logic [dtf_pkg::VALUE_W-1:0]         r_value;
    logic [dtf_pkg::STATUS_W-1:0]        r_status;

    logic [3:0]                          w_dig;
    logic [dtf_pkg::FRAC_CNT_W-1:0]      w_nd;
    logic [REM_W-1:0]                    w_shift;
    logic                                w_ge;
    logic [REM_W-1:0]                    w_rem_nxt;
    logic                                w_sat;
    logic [63:0]                         w_ip_wide;
    logic [dtf_pkg::MAG_W-1:0]           w_mag;
    logic [dtf_pkg::VALUE_W-1:0]         w_pos;

    assign w_dig = i_char[3:0];

    always_comb begin
        o_sts.is_nul    = (i_char == dtf_pkg::CH_NUL);
        o_sts.is_digit  = (i_char >= dtf_pkg::CH_0) && (i_char <= dtf_pkg::CH_9);
        o_sts.is_minus  = (i_char == dtf_pkg::CH_MINUS);
        o_sts.is_plus   = (i_char == dtf_pkg::CH_PLUS);
        o_sts.is_point  = (i_char == dtf_pkg::CH_POINT);
        o_sts.len_hit   = ({1'b0, r_cnt} + 17'd1) >= {1'b0, i_max_len};
        o_sts.int_seen  = r_int_seen;
        o_sts.frac_full = (r_frac_cnt >= 4'(dtf_pkg::MAX_FRAC_DIGITS));
        o_sts.div_last  = (r_step == STEP_W'(FRAC_BITS - 1));
    end

    assign w_nd      = (r_frac_cnt > 4'd9) ? 4'd9 : r_frac_cnt;
    assign w_shift   = {r_rem[REM_W-2:0], 1'b0};
    assign w_ge      = w_shift >= {1'b0, r_div};
    assign w_rem_nxt = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;

    assign w_ip_wide = 64'(r_int);
    assign w_sat     = (w_ip_wide >> IP_W) != 64'd0;
    assign w_mag     = w_sat ? {dtf_pkg::MAG_W{1'b1}}
                             : (dtf_pkg::MAG_W'(w_ip_wide << FRAC_BITS)
                                | dtf_pkg::MAG_W'(r_quo));
    assign w_pos     = {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg      <= 1'b0;
            r_int      <= '0;
            r_int_seen <= 1'b0;
            r_frac     <= '0;
            r_frac_cnt <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.clear) begin
            r_neg      <= 1'b0;
            r_int      <= '0;
            r_int_seen <= 1'b0;
            r_frac     <= '0;
            r_frac_cnt <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 16'd1;
            end
            if (i_cmd.int_dig) begin
                r_int      <= (r_int << 3) + (r_int << 1) + 32'(w_dig);
                r_int_seen <= 1'b1;
            end
            if (i_cmd.frac_dig) begin
                r_frac     <= (r_frac << 3) + (r_frac << 1) + 30'(w_dig);
                r_frac_cnt <= r_frac_cnt + 4'd1;
            end
            if (i_cmd.sign_load) begin
                r_neg <= o_sts.is_minus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= {1'b0, r_frac};
            r_div  <= dtf_pkg::pow10(w_nd);
            r_quo  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_rem_nxt;
            r_quo  <= {r_quo[FRAC_BITS-2:0], w_ge};
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_value  <= '0;
            r_status <= i_cmd.err_code;
        end else if (i_cmd.load_val) begin
            r_value  <= r_neg ? (dtf_pkg::VALUE_W'(0) - w_pos) : w_pos;
            r_status <= dtf_pkg::ST_OK;
        end
    end

    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// ===== rtl/dtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtf_ctrl
// Parser state machine: steps through sign, integer, fraction and drop
// stages, sequences the divider and owns the output valid flag.
// ----------------------------------------------------------------------------
module dtf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_vld,
    input  logic          i_out_rdy,
    input  dtf_pkg::t_sts i_sts,
    output logic          o_in_rdy,
    output logic          o_out_vld,
    output dtf_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_SIGN = 3'd0;
    localparam logic [2:0] S_INT  = 3'd1;
    localparam logic [2:0] S_FRAC = 3'd2;
    localparam logic [2:0] S_DROP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       w_acc;
    logic       w_ok;

    assign o_in_rdy = (r_state != S_DIV) && (r_state != S_FIN)
                      && (!r_out_vld || i_out_rdy);
    assign w_acc    = i_in_vld && o_in_rdy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        w_ok    = i_sts.is_digit
                  || ((r_state == S_SIGN)
                      && (i_sts.is_minus || i_sts.is_plus || i_sts.is_point))
                  || ((r_state == S_INT) && i_sts.is_point);
        unique case (r_state) inside
            S_SIGN, S_INT, S_FRAC: begin
                if (w_acc) begin
                    if (i_sts.is_nul) begin
                        if ((r_state == S_SIGN)
                            || ((r_state == S_INT) && !i_sts.int_seen)) begin
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = dtf_pkg::ST_NODIGIT;
                            o_cmd.clear    = 1'b1;
                            n_state        = S_SIGN;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end else if (!w_ok) begin
                        o_cmd.load_err = 1'b1;
                        o_cmd.err_code = dtf_pkg::ST_BAD;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_DROP;
                    end else if (i_sts.len_hit) begin
                        o_cmd.load_err = 1'b1;
                        o_cmd.err_code = dtf_pkg::ST_LONG;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_DROP;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        if (i_sts.is_digit) begin
                            if (r_state == S_FRAC) begin
                                o_cmd.frac_dig = !i_sts.frac_full;
                            end else begin
                                o_cmd.int_dig = 1'b1;
                                n_state       = S_INT;
                            end
                        end else if (i_sts.is_point) begin
                            n_state = S_FRAC;
                        end else begin
                            o_cmd.sign_load = 1'b1;
                            n_state         = S_INT;
                        end
                    end
                end
            end
            S_DROP: begin
                if (w_acc && i_sts.is_nul) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_SIGN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.load_val = 1'b1;
                o_cmd.clear    = 1'b1;
                n_state        = S_SIGN;
            end
            default: begin
                o_cmd.clear = 1'b1;
                n_state     = S_SIGN;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (i_out_rdy) begin
            n_out_vld = 1'b0;
        end
        if (o_cmd.load_err || o_cmd.load_val) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SIGN;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_vld = r_out_vld;

`ifndef SYNTHESIS
    a_fin_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_out_vld)
        else $error("result load while output register busy");

    a_fin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ($past(r_state) == S_DIV))
        else $error("load state entered without divide");

    a_nul_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_sts.is_nul && (r_state == S_INT) && i_sts.int_seen)
        |=> (r_state == S_DIV))
        else $error("terminator did not start divide");

    a_vld_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(w_acc) || ($past(r_state) == S_FIN)))
        else $error("result appeared without a cause");
`endif

endmodule

// ===== rtl/decimal_text_to_fixed_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_parser
// Streams ASCII decimal text in and returns signed fixed-point numbers or
// error codes, one result per NUL-terminated number or per error.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the output register is free or
// being drained. A NUL that completes a valid number stalls the input while
// the bit-serial restoring divider takes its FRAC_BITS steps to turn the
// decimal fraction into binary, and while the result is formed and loaded.
// Errors are reported in the cycle after the offending character; after a
// bad or length-exceeding character the parser drops input through the next
// NUL. max_length is written at APB address 0x0 and resets to 32.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_parser #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtf_pkg::CHAR_W-1:0]          s_tdata,   // [7:0] text_char
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtf_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [48:0] value, [50:49] status
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    dtf_pkg::t_cmd                  w_cmd;
    dtf_pkg::t_sts                  w_sts;
    logic [dtf_pkg::LEN_W-1:0]      w_max_len;
    logic [dtf_pkg::VALUE_W-1:0]    w_value;
    logic [dtf_pkg::STATUS_W-1:0]   w_status;

    dtf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    dtf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (s_tdata),
        .i_max_len (w_max_len),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_value   (w_value),
        .o_status  (w_status)
    );

    dtf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_tvalid),
        .i_out_rdy (m_tready),
        .i_sts     (w_sts),
        .o_in_rdy  (s_tready),
        .o_out_vld (m_tvalid),
        .o_cmd     (w_cmd)
    );

    assign m_tdata = {5'd0, w_status, w_value};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for decimal_text_to_fixed_parser. A table of short
// numbers covers signs, points, wrap, long fractions, bad characters and
// missing digits, then random text (mostly well-formed numbers, some broken,
// some raw bytes) runs under several max_length settings and stall patterns.
// Every returned value and status is compared with the table or a bench model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_BITS     = 16;
    localparam int          SETTLE_CYCLES = FRAC_BITS + 8;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          N_DIRECTED    = 15;
    localparam logic [2:0]  ADDR_MAX_LEN  = {dtf_pkg::REG_MAX_LEN, 2'b00};
    localparam logic [63:0] MAG_MAX       = 64'h0000_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {PM_SIGN, PM_INT, PM_FRAC, PM_DROP} t_parse_mode;

    typedef struct packed {
        logic [dtf_pkg::VALUE_W-1:0]  value;
        logic [dtf_pkg::STATUS_W-1:0] status;
    } t_fixed_result;

    typedef struct {
        string                        text;
        bit                           typed;
        logic [dtf_pkg::VALUE_W-1:0]  value;
        logic [dtf_pkg::STATUS_W-1:0] status;
    } t_directed_row;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [dtf_pkg::CHAR_W-1:0]      s_tdata  = '0;   // [7:0] text_char
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [dtf_pkg::OUT_TDATA_W-1:0] m_tdata;  // [48:0] value, [50:49] status
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [2:0]                      paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    decimal_text_to_fixed_parser #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // parser model state
    logic [dtf_pkg::LEN_W-1:0]      max_len_cfg = 16'd32;
    t_parse_mode                    mode        = PM_SIGN;
    logic                           negative    = 1'b0;
    logic [dtf_pkg::INT_W-1:0]      int_acc     = '0;
    logic                           int_seen    = 1'b0;
    logic [dtf_pkg::FRAC_ACC_W-1:0] frac_acc    = '0;
    logic [dtf_pkg::FRAC_CNT_W-1:0] frac_cnt    = '0;
    logic [dtf_pkg::LEN_W-1:0]      char_cnt    = '0;

    t_fixed_result expected_results[$];
    t_fixed_result forced_result;
    bit            force_pending = 1'b0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int chars_parsed = 0;
    int results_seen = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int settings_used = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{"",                 1'b1, 49'd0,       dtf_pkg::ST_NODIGIT},
        '{"-",                1'b1, 49'd0,       dtf_pkg::ST_NODIGIT},
        '{"7",                1'b1, 49'h7_0000,  dtf_pkg::ST_OK},
        '{".5",               1'b1, 49'h8000,    dtf_pkg::ST_OK},
        '{"-.",               1'b1, 49'd0,       dtf_pkg::ST_OK},
        '{"+0",               1'b1, 49'd0,       dtf_pkg::ST_OK},
        '{"-0.0",             1'b1, 49'd0,       dtf_pkg::ST_OK},
        '{"1..",              1'b1, 49'd0,       dtf_pkg::ST_BAD},
        '{"1-",               1'b1, 49'd0,       dtf_pkg::ST_BAD},
        '{"a",                1'b1, 49'd0,       dtf_pkg::ST_BAD},
        '{"\377",             1'b1, 49'd0,       dtf_pkg::ST_BAD},
        '{"4294967296",       1'b1, 49'd0,       dtf_pkg::ST_OK},
        '{"-1.5",             1'b0, 49'd0,       dtf_pkg::ST_OK},
        '{"4294967295.99999", 1'b0, 49'd0,       dtf_pkg::ST_OK},
        '{"-.1234567891",     1'b0, 49'd0,       dtf_pkg::ST_OK}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready = ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what,
                     want, got);
    endtask

    task automatic clear_number();
        mode     = PM_SIGN;
        negative = 1'b0;
        int_acc  = '0;
        int_seen = 1'b0;
        frac_acc = '0;
        frac_cnt = '0;
        char_cnt = '0;
    endtask

    task automatic post_result(input logic [dtf_pkg::VALUE_W-1:0] v,
                               input logic [dtf_pkg::STATUS_W-1:0] s);
        t_fixed_result r;
        if (force_pending) begin
            r = forced_result;
            force_pending = 1'b0;
        end else begin
            r.value  = v;
            r.status = s;
        end
        expected_results.push_back(r);
    endtask

    task automatic post_error(input logic [dtf_pkg::STATUS_W-1:0] code, input bit drop);
        clear_number();
        if (drop)
            mode = PM_DROP;
        post_result('0, code);
    endtask

    task automatic post_value();
        logic [63:0] divisor;
        logic [63:0] frac_part;
        logic [63:0] mag;
        divisor = 64'd1;
        repeat (frac_cnt) divisor = divisor * 64'd10;
        frac_part = ({34'd0, frac_acc} << FRAC_BITS) / divisor;
        mag = ({32'd0, int_acc} << FRAC_BITS) + frac_part;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        if (negative)
            mag = -mag;
        post_result(mag[dtf_pkg::VALUE_W-1:0], dtf_pkg::ST_OK);
        clear_number();
    endtask

    task automatic parse_char(input logic [dtf_pkg::CHAR_W-1:0] c);
        logic       is_dig;
        logic [3:0] dv;
        logic       ok;
        is_dig = (c >= dtf_pkg::CH_0) && (c <= dtf_pkg::CH_9);
        dv = 4'(c - dtf_pkg::CH_0);
        if (mode == PM_DROP) begin
            if (c == dtf_pkg::CH_NUL)
                clear_number();
        end else if (c == dtf_pkg::CH_NUL) begin
            if (mode == PM_SIGN || (mode == PM_INT && !int_seen))
                post_error(dtf_pkg::ST_NODIGIT, 1'b0);
            else
                post_value();
        end else begin
            ok = is_dig
                 || (mode == PM_SIGN && (c == dtf_pkg::CH_MINUS || c == dtf_pkg::CH_PLUS
                                         || c == dtf_pkg::CH_POINT))
                 || (mode == PM_INT && c == dtf_pkg::CH_POINT);
            if (!ok) begin
                post_error(dtf_pkg::ST_BAD, 1'b1);
            end else if ({16'd0, char_cnt} + 32'd1 >= {16'd0, max_len_cfg}) begin
                post_error(dtf_pkg::ST_LONG, 1'b1);
            end else begin
                char_cnt = char_cnt + 1'b1;
                if (is_dig) begin
                    if (mode == PM_FRAC) begin
                        if (frac_cnt < dtf_pkg::MAX_FRAC_DIGITS) begin
                            frac_acc = frac_acc * 30'd10 + 30'(dv);
                            frac_cnt = frac_cnt + 1'b1;
                        end
                    end else begin
                        int_acc  = int_acc * 32'd10 + 32'(dv);
                        int_seen = 1'b1;
                        mode     = PM_INT;
                    end
                end else if (c == dtf_pkg::CH_POINT) begin
                    mode = PM_FRAC;
                end else begin
                    negative = (c == dtf_pkg::CH_MINUS);
                    mode     = PM_INT;
                end
            end
        end
    endtask

    task automatic send_char(input logic [dtf_pkg::CHAR_W-1:0] c);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        do @(posedge i_clk); while (!s_tready);
        chars_parsed++;
        parse_char(c);
    endtask

    task automatic send_random_number();
        logic [dtf_pkg::CHAR_W-1:0] txt[$];
        string                      top_int;
        int                         kind;
        int                         n;
        int                         pos;
        logic [dtf_pkg::CHAR_W-1:0] extra;
        top_int = "4294967295";
        kind = $urandom_range(99);
        if (kind < 80) begin
            case ($urandom_range(3))
                0:       txt.push_back(dtf_pkg::CH_MINUS);
                1:       txt.push_back(dtf_pkg::CH_PLUS);
                default: ;
            endcase
            if ($urandom_range(19) == 0) begin
                for (int i = 0; i < top_int.len(); i++)
                    txt.push_back(top_int[i]);
            end else begin
                n = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
                repeat (n) txt.push_back(dtf_pkg::CH_0 + 8'($urandom_range(9)));
            end
            if ($urandom_range(1)) begin
                txt.push_back(dtf_pkg::CH_POINT);
                n = ($urandom_range(5) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
                repeat (n) txt.push_back(dtf_pkg::CH_0 + 8'($urandom_range(9)));
            end
            if (kind >= 65) begin
                case ($urandom_range(4))
                    0:       extra = dtf_pkg::CH_MINUS;
                    1:       extra = dtf_pkg::CH_PLUS;
                    2:       extra = dtf_pkg::CH_POINT;
                    3:       extra = dtf_pkg::CH_NUL;
                    default: extra = 8'($urandom_range(1, 255));
                endcase
                pos = $urandom_range(txt.size());
                txt.insert(pos, extra);
            end
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) txt.push_back(8'($urandom_range(255)));
        end
        txt.push_back(dtf_pkg::CH_NUL);
        foreach (txt[i]) send_char(txt[i]);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_max_len_reg();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_MAX_LEN;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[dtf_pkg::LEN_W-1:0] !== max_len_cfg)
            note_mismatch("max_length readback", 64'(max_len_cfg), 64'(prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_max_len(input logic [dtf_pkg::LEN_W-1:0] len);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_MAX_LEN;
        pwdata  = {16'd0, len};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        max_len_cfg = len;
        settings_used++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_max_len_reg();
    endtask

    task automatic run_random(input logic [dtf_pkg::LEN_W-1:0] len, input int snd_pct,
                              input int rcv_pct, input int n_chars);
        int start;
        settle();
        set_max_len(len);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        start = chars_parsed;
        while (chars_parsed - start < n_chars) send_random_number();
    endtask

    always @(posedge i_clk) begin
        t_fixed_result got;
        t_fixed_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.value  = m_tdata[dtf_pkg::VALUE_W-1:0];
            got.status = m_tdata[dtf_pkg::VALUE_W+dtf_pkg::STATUS_W-1:dtf_pkg::VALUE_W];
            results_seen++;
            status_seen[got.status]++;
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected transfer", 64'd0, 64'(got));
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value)
                    note_mismatch("value", 64'(want.value), 64'(got.value));
                if (got.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(got.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        snd_idle_pct = 28;
        rcv_idle_pct = 75;
        check_max_len_reg();
        set_max_len(16'd32);
        foreach (directed_rows[r]) begin
            force_pending = directed_rows[r].typed;
            forced_result.value  = directed_rows[r].value;
            forced_result.status = directed_rows[r].status;
            for (int i = 0; i < directed_rows[r].text.len(); i++)
                send_char(directed_rows[r].text[i]);
            send_char(dtf_pkg::CH_NUL);
        end

        run_random(16'd1, 28, 75, 150);
        run_random(16'd32, 28, 75, 200);
        run_random(16'd12, 75, 28, 300);
        run_random(16'($urandom_range(2, 40)), 75, 28, 300);
        run_random(16'd65535, 0, 0, 200);
        run_random(16'd7, 0, 0, 250);

        settle();
        $display("Parsed %0d characters over %0d max_length settings; %0d results checked",
                 chars_parsed, settings_used, results_seen);
        $display("Status mix: ok %0d, bad char %0d, no digits %0d, too long %0d",
                 status_seen[dtf_pkg::ST_OK], status_seen[dtf_pkg::ST_BAD],
                 status_seen[dtf_pkg::ST_NODIGIT], status_seen[dtf_pkg::ST_LONG]);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
